[rtl/lsal_pkg.sv]
// Shared types, widths and constants of the light sensor auto-gain and lux block.
// No dependencies; compile before the interfaces and the top level.
package lsal_pkg;

  localparam int CH_W       = 16;
  localparam int MS_W       = 10;
  localparam int GAIN_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int LUX_W      = 32;
  localparam int CTRL_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int ATT_W      = 2;

  localparam int MUL_W    = 41;
  localparam int MPLIER_W = 16;
  localparam int DEN_W    = 40;
  localparam int CNT_W    = 5;
  localparam int NUM_HI_W = 17;

  localparam logic [CH_W-1:0]     SAT_LIMIT_SHORT = 16'd36863;
  localparam logic [CH_W-1:0]     SAT_LIMIT_LONG  = 16'd65535;
  localparam logic [CH_W-1:0]     LOW_COUNT       = 16'd100;
  localparam logic [MS_W-1:0]     MS_SHORT        = 10'd100;
  localparam logic [MPLIER_W-1:0] LUX_SCALE       = 16'd408;
  localparam logic [5:0]          MS_RECIP        = 6'd41;
  localparam int                  MS_RECIP_SHIFT  = 12;

  localparam logic [MS_W-1:0]   MS_RESET   = 10'd100;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 2'd1;
  localparam logic [GAIN_W-1:0] GAIN_MAX   = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_VALID = 2'd0,
    ST_RETRY = 2'd1,
    ST_FAIL  = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTEG_MS  = 2'd0,
    REG_AUTO_GAIN = 2'd1,
    REG_INIT_GAIN = 2'd2
  } cfg_reg_e;

  function automatic logic [MPLIER_W-1:0] gain_value(input logic [GAIN_W-1:0] idx);
    logic [MPLIER_W-1:0] g;
    case (idx)
      2'd0:    g = 16'd1;
      2'd1:    g = 16'd25;
      2'd2:    g = 16'd428;
      default: g = 16'd9876;
    endcase
    return g;
  endfunction

endpackage

[rtl/lsal_intf.sv]
// Valid/ready channel interfaces: reading input, result output, register write.
// Depends on lsal_pkg for field widths.
interface lsal_in_if;
  import lsal_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] channel_full;
  logic [CH_W-1:0] channel_ir;
  logic            bus_error;

  modport source(output valid, channel_full, channel_ir, bus_error, input ready);
  modport sink(input valid, channel_full, channel_ir, bus_error, output ready);
endinterface

interface lsal_out_if;
  import lsal_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [LUX_W-1:0]    lux_q8;
  logic [GAIN_W-1:0]   gain_now;
  logic [CTRL_W-1:0]   control_byte;

  modport source(output valid, status, lux_q8, gain_now, control_byte, input ready);
  modport sink(input valid, status, lux_q8, gain_now, control_byte, output ready);
endinterface

interface lsal_cfg_if;
  import lsal_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[rtl/light_sensor_autogain_lux.sv]
// Auto-gain control and lux calculation for a two-channel light sensor reading.
// Depends on lsal_pkg and the channel interfaces in lsal_intf.sv.
// One item at a time; a result held by the receiver stalls the next transfer.
// Retry, fail, zero-count: straight to the finish load, taken once the output is free. Lux:
// square, scale and two denominator multiply passes, divide (skipped on saturation), load.
// Reset (async, active low): integration 100 ms, auto-gain on, gain index 1, no attempts.
module light_sensor_autogain_lux #(
  parameter int MAX_ATTEMPTS = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lsal_in_if.sink    in_ch_i,
  lsal_out_if.source out_ch_o,
  lsal_cfg_if.sink   cfg_i
);
  import lsal_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_SCALE,
    S_DEN_A,
    S_DEN_B,
    S_DIVIDE,
    S_FINISH
  } state_e;

  state_e                state_q;
  logic [MS_W-1:0]       ms_q;
  logic                  auto_q;
  logic [GAIN_W-1:0]     gain_q;
  logic [ATT_W-1:0]      attempt_q;
  status_e               status_q;
  logic [CH_W-1:0]       c0_q;
  logic [MUL_W-1:0]      mcand_q;
  logic [MPLIER_W-1:0]   mplier_q;
  logic [MUL_W-1:0]      acc_q;
  logic [DEN_W-1:0]      den_q;
  logic [MUL_W-1:0]      rem_q;
  logic [LUX_W-1:0]      qsh_q;
  logic [CNT_W-1:0]      cnt_q;

  logic                  out_valid_q;
  status_e               out_status_q;
  logic [LUX_W-1:0]      out_lux_q;
  logic [GAIN_W-1:0]     out_gain_q;
  logic [CTRL_W-1:0]     out_ctrl_q;

  logic                  in_xfer;
  logic [CH_W-1:0]       c0;
  logic [CH_W-1:0]       c1;
  logic [CH_W-1:0]       sat_limit;
  logic                  can_retry;
  status_e               dec_status;
  logic [GAIN_W-1:0]     dec_gain;
  logic                  dec_compute;
  logic [CH_W-1:0]       diff;

  logic                  mul_done;
  logic [MUL_W-1:0]      acc_add;
  logic [MUL_W-1:0]      trial;
  logic [MUL_W-1:0]      den_ext;
  logic                  fits;
  logic                  lux_sat;

  logic [CH_W-1:0]       ms_prod;
  logic [3:0]            integ_bits;
  logic [CTRL_W-1:0]     ctrl_byte;
  logic                  out_free;

  assign in_ch_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready   = 1'b1;
  assign in_xfer       = in_ch_i.valid && in_ch_i.ready;

  assign c0        = in_ch_i.channel_full;
  assign c1        = in_ch_i.channel_ir;
  assign sat_limit = (ms_q == MS_SHORT) ? SAT_LIMIT_SHORT : SAT_LIMIT_LONG;
  assign can_retry = ({1'b0, attempt_q} + 3'd1) < 3'(MAX_ATTEMPTS);
  assign diff      = (c0 >= c1) ? (c0 - c1) : (c1 - c0);

  always_comb begin
    dec_status  = ST_VALID;
    dec_gain    = gain_q;
    dec_compute = 1'b0;
    if (in_ch_i.bus_error) begin
      dec_status = ST_FAIL;
    end else if (c0 >= sat_limit || c1 >= sat_limit) begin
      if (auto_q && gain_q != '0 && can_retry) begin
        dec_gain   = gain_q - 2'd1;
        dec_status = ST_RETRY;
      end else begin
        dec_status = ST_FAIL;
      end
    end else if (auto_q && c0 < LOW_COUNT && gain_q != GAIN_MAX && can_retry) begin
      dec_gain   = gain_q + 2'd1;
      dec_status = ST_RETRY;
    end else if (c0 == '0) begin
      dec_status = ST_VALID;
    end else if (ms_q == '0) begin
      dec_status = ST_FAIL;
    end else begin
      dec_compute = 1'b1;
    end
  end

  assign mul_done = (mplier_q == '0);
  assign acc_add  = acc_q + (mplier_q[0] ? mcand_q : '0);

  assign den_ext = {1'b0, den_q};
  assign trial   = {rem_q[MUL_W-2:0], qsh_q[LUX_W-1]};
  assign fits    = (trial >= den_ext);
  assign lux_sat = (acc_q[DEN_W-1:NUM_HI_W] == '0) &&
                   (acc_q[NUM_HI_W-1:0] <= rem_q[NUM_HI_W-1:0]);

  assign ms_prod    = 16'({6'b0, ms_q} * {10'b0, MS_RECIP});
  assign integ_bits = ms_prod[CH_W-1:MS_RECIP_SHIFT] - 4'd1;
  assign ctrl_byte  = {2'b00, gain_q, integ_bits};
  assign out_free   = !out_valid_q || out_ch_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ms_q         <= MS_RESET;
      auto_q       <= 1'b1;
      gain_q       <= GAIN_RESET;
      attempt_q    <= '0;
      status_q     <= ST_VALID;
      c0_q         <= '0;
      mcand_q      <= '0;
      mplier_q     <= '0;
      acc_q        <= '0;
      den_q        <= '0;
      rem_q        <= '0;
      qsh_q        <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_VALID;
      out_lux_q    <= '0;
      out_gain_q   <= '0;
      out_ctrl_q   <= '0;
    end else begin
      if (out_valid_q && out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            status_q  <= dec_status;
            gain_q    <= dec_gain;
            attempt_q <= (dec_status == ST_RETRY) ? attempt_q + 2'd1 : '0;
            c0_q      <= c0;
            qsh_q     <= '0;
            mcand_q   <= MUL_W'(diff);
            mplier_q  <= diff;
            acc_q     <= '0;
            state_q   <= dec_compute ? S_SQUARE : S_FINISH;
          end
        end
        S_SQUARE: begin
          if (mul_done) begin
            mcand_q  <= acc_q;
            mplier_q <= LUX_SCALE;
            acc_q    <= '0;
            state_q  <= S_SCALE;
          end else begin
            acc_q    <= acc_add;
            mcand_q  <= {mcand_q[MUL_W-2:0], 1'b0};
            mplier_q <= {1'b0, mplier_q[MPLIER_W-1:1]};
          end
        end
        S_SCALE: begin
          if (mul_done) begin
            rem_q    <= MUL_W'(acc_q[MUL_W-1:MUL_W-NUM_HI_W]);
            qsh_q    <= {acc_q[MUL_W-NUM_HI_W-1:0], 8'b0};
            mcand_q  <= MUL_W'(c0_q);
            mplier_q <= MPLIER_W'(ms_q);
            acc_q    <= '0;
            state_q  <= S_DEN_A;
          end else begin
            acc_q    <= acc_add;
            mcand_q  <= {mcand_q[MUL_W-2:0], 1'b0};
            mplier_q <= {1'b0, mplier_q[MPLIER_W-1:1]};
          end
        end
        S_DEN_A: begin
          if (mul_done) begin
            mcand_q  <= acc_q;
            mplier_q <= gain_value(gain_q);
            acc_q    <= '0;
            state_q  <= S_DEN_B;
          end else begin
            acc_q    <= acc_add;
            mcand_q  <= {mcand_q[MUL_W-2:0], 1'b0};
            mplier_q <= {1'b0, mplier_q[MPLIER_W-1:1]};
          end
        end
        S_DEN_B: begin
          if (mul_done) begin
            den_q <= acc_q[DEN_W-1:0];
            cnt_q <= '1;
            if (lux_sat) begin
              qsh_q   <= '1;
              state_q <= S_FINISH;
            end else begin
              state_q <= S_DIVIDE;
            end
          end else begin
            acc_q    <= acc_add;
            mcand_q  <= {mcand_q[MUL_W-2:0], 1'b0};
            mplier_q <= {1'b0, mplier_q[MPLIER_W-1:1]};
          end
        end
        S_DIVIDE: begin
          rem_q <= fits ? (trial - den_ext) : trial;
          qsh_q <= {qsh_q[LUX_W-2:0], fits};
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == '0) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_lux_q    <= qsh_q;
            out_gain_q   <= gain_q;
            out_ctrl_q   <= ctrl_byte;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          REG_INTEG_MS:  ms_q   <= cfg_i.data;
          REG_AUTO_GAIN: auto_q <= cfg_i.data[0];
          REG_INIT_GAIN: gain_q <= cfg_i.data[GAIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_ch_o.valid        = out_valid_q;
  assign out_ch_o.status       = out_status_q;
  assign out_ch_o.lux_q8       = out_lux_q;
  assign out_ch_o.gain_now     = out_gain_q;
  assign out_ch_o.control_byte = out_ctrl_q;

  a_attempt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, attempt_q} < 3'(MAX_ATTEMPTS)))
    else $error("attempt count beyond retry budget");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVIDE) |-> (rem_q < den_ext))
    else $error("divider remainder not below denominator");

  a_lux_zero_unless_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != ST_VALID) |-> (out_lux_q == '0))
    else $error("lux nonzero on retry or fail result");

  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ch_i.ready)
    else $error("input taken again before result finished");

endmodule
